FILE: rtl/sab_pkg.sv
// sab_pkg: constants, register codes and pipeline types of the scaled alpha blitter.
// No dependencies; used by the channel interfaces and by scaled_alpha_blit.
package sab_pkg;

    // Source image and screen limits
    localparam int MAX_SOURCE_DIM = 256;
    localparam int SCREEN_WIDTH   = 1280;
    localparam int SCREEN_HEIGHT  = 720;

    // Field widths
    localparam int CMD_W    = 1;
    localparam int ADDR_W   = 16;
    localparam int PIX_W    = 32;
    localparam int COL_W    = 11;
    localparam int DIM_W    = 9;
    localparam int ORG_W    = 12;
    localparam int POS_W    = ORG_W + 1;
    localparam int SX_W     = 11;
    localparam int SY_W     = 10;
    localparam int NUM_W    = COL_W + DIM_W;
    localparam int QUOT_W   = $clog2(MAX_SOURCE_DIM);
    localparam int STORE_DEPTH = 1 << ADDR_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd5;

    // Item commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_BLEND = 1'b1;

    // Alpha codes
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Per-item data that travels down the pipeline
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic              keep;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic [SX_W-1:0]   sx;
        logic [SY_W-1:0]   sy;
    } sab_meta_t;

endpackage

FILE: rtl/sab_item_if.sv
// sab_item_if: input channel of the blitter (valid/ready plus item fields).
// Depends on sab_pkg for field widths.
interface sab_item_if;
    logic                         valid;
    logic                         ready;
    logic [sab_pkg::CMD_W-1:0]    cmd;
    logic [sab_pkg::ADDR_W-1:0]   source_address;
    logic [sab_pkg::PIX_W-1:0]    source_rgba;
    logic [sab_pkg::COL_W-1:0]    rect_column;
    logic [sab_pkg::COL_W-1:0]    rect_row;
    logic [sab_pkg::PIX_W-1:0]    old_rgba;

    modport source (
        output valid, cmd, source_address, source_rgba, rect_column, rect_row, old_rgba,
        input  ready
    );
    modport sink (
        input  valid, cmd, source_address, source_rgba, rect_column, rect_row, old_rgba,
        output ready
    );
endinterface

FILE: rtl/sab_result_if.sv
// sab_result_if: output channel of the blitter (valid/ready plus result fields).
// Depends on sab_pkg for field widths.
interface sab_result_if;
    logic                        valid;
    logic                        ready;
    logic                        write_enable;
    logic [sab_pkg::SX_W-1:0]    screen_x;
    logic [sab_pkg::SY_W-1:0]    screen_y;
    logic [sab_pkg::PIX_W-1:0]   new_rgba;

    modport source (
        output valid, write_enable, screen_x, screen_y, new_rgba,
        input  ready
    );
    modport sink (
        input  valid, write_enable, screen_x, screen_y, new_rgba,
        output ready
    );
endinterface

FILE: rtl/scaled_alpha_blit.sv
// scaled_alpha_blit: top level of the nearest-neighbor scaled alpha blitter.
// Depends on sab_pkg, sab_item_if, sab_result_if and sab_ram.
//
// The block takes one item per clock while the output is not stalled, loads and
// blends mixed in any order, and returns exactly one result per item in order.
// An item passes through one setup stage, an 8-stage restoring divider (one
// quotient bit per stage, x and y side by side), the source address stage, the
// source store access, the channel multiply and the divide-by-255 output stage.
// Loads write the source store at the same pipeline position where blends read
// it, so stores and reads stay in item order without forwarding. A stalled output
// freezes the whole pipeline; the source store read data holds across the stall.
// The store has no reset: a blend that hits an entry never loaded returns
// undefined color. Configuration is written through cfg_we/cfg_index/cfg_data and
// must only change while the pipeline is empty.
module scaled_alpha_blit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sab_pkg::CFG_DATA_W-1:0]   cfg_data,
    sab_item_if.sink                         item,
    sab_result_if.source                     result
);

    localparam int NSTG = sab_pkg::QUOT_W;

    // Configuration registers
    logic [sab_pkg::DIM_W-1:0] source_width_reg;
    logic [sab_pkg::DIM_W-1:0] source_height_reg;
    logic [sab_pkg::COL_W-1:0] target_width_reg;
    logic [sab_pkg::COL_W-1:0] target_height_reg;
    logic [sab_pkg::ORG_W-1:0] origin_x_reg;
    logic [sab_pkg::ORG_W-1:0] origin_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= sab_pkg::DIM_W'(1);
            source_height_reg <= sab_pkg::DIM_W'(1);
            target_width_reg  <= '0;
            target_height_reg <= '0;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sab_pkg::REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[sab_pkg::DIM_W-1:0];
                sab_pkg::REG_SOURCE_HEIGHT: source_height_reg <= cfg_data[sab_pkg::DIM_W-1:0];
                sab_pkg::REG_TARGET_WIDTH:  target_width_reg  <= cfg_data[sab_pkg::COL_W-1:0];
                sab_pkg::REG_TARGET_HEIGHT: target_height_reg <= cfg_data[sab_pkg::COL_W-1:0];
                sab_pkg::REG_ORIGIN_X:      origin_x_reg      <= cfg_data[sab_pkg::ORG_W-1:0];
                sab_pkg::REG_ORIGIN_Y:      origin_y_reg      <= cfg_data[sab_pkg::ORG_W-1:0];
                default: ;
            endcase
        end
    end

    // Derived geometry (the user must keep it static while items are in flight; the block does not enforce this)
    logic [sab_pkg::DIM_W-1:0] sw;
    logic [sab_pkg::DIM_W-1:0] sh;
    logic [sab_pkg::COL_W-1:0] dw;
    logic [sab_pkg::COL_W-1:0] dh;

    always_comb
    begin
        sw = (32'(source_width_reg) > sab_pkg::MAX_SOURCE_DIM)
            ? sab_pkg::DIM_W'(sab_pkg::MAX_SOURCE_DIM) : source_width_reg;
        sh = (32'(source_height_reg) > sab_pkg::MAX_SOURCE_DIM)
            ? sab_pkg::DIM_W'(sab_pkg::MAX_SOURCE_DIM) : source_height_reg;
        dw = (target_width_reg != '0) ? target_width_reg : sab_pkg::COL_W'(sw);
        dh = (target_height_reg != '0) ? target_height_reg : sab_pkg::COL_W'(sh);
    end

    // Pipeline advance: everything moves unless the output register is blocked
    logic out_valid_reg;
    logic adv;

    assign adv        = !out_valid_reg || result.ready;
    assign item.ready = adv;

    // Setup stage: clip tests, screen position and division numerators
    logic [sab_pkg::POS_W-1:0] x_sum;
    logic [sab_pkg::POS_W-1:0] y_sum;
    logic                      in_rect;
    logic                      on_screen;
    sab_pkg::sab_meta_t        setup_next;
    logic [sab_pkg::NUM_W-1:0] numx_next;
    logic [sab_pkg::NUM_W-1:0] numy_next;

    always_comb
    begin
        x_sum = {origin_x_reg[sab_pkg::ORG_W-1], origin_x_reg}
              + {{(sab_pkg::POS_W-sab_pkg::COL_W){1'b0}}, item.rect_column};
        y_sum = {origin_y_reg[sab_pkg::ORG_W-1], origin_y_reg}
              + {{(sab_pkg::POS_W-sab_pkg::COL_W){1'b0}}, item.rect_row};
        in_rect = (sw != '0) && (sh != '0)
               && (item.rect_column < dw) && (item.rect_row < dh);
        on_screen = !x_sum[sab_pkg::POS_W-1] && !y_sum[sab_pkg::POS_W-1]
                 && (x_sum < sab_pkg::POS_W'(sab_pkg::SCREEN_WIDTH))
                 && (y_sum < sab_pkg::POS_W'(sab_pkg::SCREEN_HEIGHT));
        setup_next.cmd  = item.cmd;
        setup_next.keep = in_rect && on_screen;
        setup_next.addr = item.source_address;
        setup_next.pix  = (item.cmd == sab_pkg::CMD_LOAD) ? item.source_rgba : item.old_rgba;
        setup_next.sx   = x_sum[sab_pkg::SX_W-1:0];
        setup_next.sy   = y_sum[sab_pkg::SY_W-1:0];
        numx_next = sab_pkg::NUM_W'(item.rect_column) * sab_pkg::NUM_W'(sw);
        numy_next = sab_pkg::NUM_W'(item.rect_row) * sab_pkg::NUM_W'(sh);
    end

    // Divider pipeline: entry 0 is the setup stage, entry NSTG the finished quotient
    logic                       vld_reg  [0:NSTG];
    sab_pkg::sab_meta_t         meta_reg [0:NSTG];
    logic [sab_pkg::NUM_W-1:0]  remx_reg [0:NSTG];
    logic [sab_pkg::NUM_W-1:0]  remy_reg [0:NSTG];
    logic [sab_pkg::QUOT_W-1:0] qx_reg   [0:NSTG];
    logic [sab_pkg::QUOT_W-1:0] qy_reg   [0:NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[0] <= setup_next;
            remx_reg[0] <= numx_next;
            remy_reg[0] <= numy_next;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar i = 0; i < NSTG; i++)
    begin : g_div
        localparam int B = NSTG - 1 - i;
        logic [sab_pkg::NUM_W-1:0] dx_sh;
        logic [sab_pkg::NUM_W-1:0] dy_sh;
        logic                      gex;
        logic                      gey;

        always_comb
        begin
            dx_sh = sab_pkg::NUM_W'(dw) << B;
            dy_sh = sab_pkg::NUM_W'(dh) << B;
            gex   = remx_reg[i] >= dx_sh;
            gey   = remy_reg[i] >= dy_sh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                meta_reg[i+1] <= meta_reg[i];
                remx_reg[i+1] <= gex ? (remx_reg[i] - dx_sh) : remx_reg[i];
                remy_reg[i+1] <= gey ? (remy_reg[i] - dy_sh) : remy_reg[i];
                qx_reg[i+1]   <= qx_reg[i] | (gex ? (sab_pkg::QUOT_W'(1) << B) : '0);
                qy_reg[i+1]   <= qy_reg[i] | (gey ? (sab_pkg::QUOT_W'(1) << B) : '0);
            end
        end
    end

    // Address stage: blends use qy*sw+qx (scaled source row and column), loads keep their own address
    logic                        a_vld_reg;
    sab_pkg::sab_meta_t          a_meta_reg;
    sab_pkg::sab_meta_t          a_meta_next;
    logic [sab_pkg::ADDR_W+2:0]  lin_addr;

    always_comb
    begin
        lin_addr = (sab_pkg::ADDR_W+3)'(qy_reg[NSTG]) * (sab_pkg::ADDR_W+3)'(sw)
                 + (sab_pkg::ADDR_W+3)'(qx_reg[NSTG]);
        a_meta_next = meta_reg[NSTG];
        if (meta_reg[NSTG].cmd == sab_pkg::CMD_BLEND)
        begin
            a_meta_next.addr = lin_addr[sab_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_vld_reg <= vld_reg[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_meta_reg <= a_meta_next;
        end
    end

    // Source store: loads write and blends read at the same pipeline position
    logic                       ram_we;
    logic                       ram_re;
    logic [sab_pkg::PIX_W-1:0]  ram_rdata;

    assign ram_we = adv && a_vld_reg && (a_meta_reg.cmd == sab_pkg::CMD_LOAD);
    assign ram_re = adv && a_vld_reg && (a_meta_reg.cmd == sab_pkg::CMD_BLEND);

    sab_ram #(
        .WIDTH (sab_pkg::PIX_W),
        .DEPTH (sab_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (a_meta_reg.addr),
        .wdata (a_meta_reg.pix),
        .re    (ram_re),
        .raddr (a_meta_reg.addr),
        .rdata (ram_rdata)
    );

    logic               r_vld_reg;
    sab_pkg::sab_meta_t r_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_meta_reg <= a_meta_reg;
        end
    end

    // Multiply stage: s*a + d*(255-a) per color channel
    logic [7:0]  src_alpha;
    logic [7:0]  inv_alpha;
    logic [15:0] mix_next [3];

    always_comb
    begin
        src_alpha = ram_rdata[31:24];
        inv_alpha = ALPHA_MAX_SUB(src_alpha);
        for (int c = 0; c < 3; c++)
        begin
            mix_next[c] = 16'(ram_rdata[8*c +: 8]) * 16'(src_alpha)
                        + 16'(r_meta_reg.pix[8*c +: 8]) * 16'(inv_alpha);
        end
    end

    logic               m_vld_reg;
    sab_pkg::sab_meta_t m_meta_reg;
    logic [7:0]         m_alpha_reg;
    logic [23:0]        m_rgb_reg;
    logic [15:0]        m_mix_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_vld_reg <= r_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_meta_reg  <= r_meta_reg;
            m_alpha_reg <= src_alpha;
            m_rgb_reg   <= ram_rdata[23:0];
            m_mix_reg   <= mix_next;
        end
    end

    // Output stage: divide by 255 as (v + 1 + (v >> 8)) >> 8, exact for v <= 255*255
    logic [16:0]               div_tmp [3];
    logic [23:0]               blend_rgb;
    logic                      we_next;
    logic [sab_pkg::PIX_W-1:0] rgba_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            div_tmp[c] = 17'(m_mix_reg[c]) + 17'(1) + 17'(m_mix_reg[c][15:8]);
            blend_rgb[8*c +: 8] = div_tmp[c][15:8];
        end
        we_next = (m_meta_reg.cmd == sab_pkg::CMD_BLEND) && m_meta_reg.keep
               && (m_alpha_reg != sab_pkg::ALPHA_CLEAR);
        rgba_next = {sab_pkg::ALPHA_OPAQUE,
                     (m_alpha_reg == sab_pkg::ALPHA_OPAQUE) ? m_rgb_reg : blend_rgb};
    end

    logic                      out_we_reg;
    logic [sab_pkg::SX_W-1:0]  out_x_reg;
    logic [sab_pkg::SY_W-1:0]  out_y_reg;
    logic [sab_pkg::PIX_W-1:0] out_rgba_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_we_reg   <= we_next;
            out_x_reg    <= we_next ? m_meta_reg.sx : '0;
            out_y_reg    <= we_next ? m_meta_reg.sy : '0;
            out_rgba_reg <= we_next ? rgba_next : '0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.write_enable = out_we_reg;
    assign result.screen_x     = out_x_reg;
    assign result.screen_y     = out_y_reg;
    assign result.new_rgba     = out_rgba_reg;

    function automatic logic [7:0] ALPHA_MAX_SUB(input logic [7:0] a);
        return sab_pkg::ALPHA_OPAQUE - a;
    endfunction

    // Checks
    a_written_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_we_reg |-> out_rgba_reg[31:24] == sab_pkg::ALPHA_OPAQUE)
        else $error("written pixel alpha not opaque");

    a_no_write_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_we_reg |->
            out_x_reg == '0 && out_y_reg == '0 && out_rgba_reg == '0)
        else $error("result fields not cleared on no-write");

    a_write_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_we_reg |->
            32'(out_x_reg) < sab_pkg::SCREEN_WIDTH && 32'(out_y_reg) < sab_pkg::SCREEN_HEIGHT)
        else $error("write outside the screen");

    a_store_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        r_vld_reg && !adv |=> $stable(ram_rdata))
        else $error("store read data changed during stall");

endmodule

FILE: rtl/sab_ram.sv
// sab_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
